>>> rtl/cfe_pkg.sv
`timescale 1ns / 1ps
package cfe_pkg;

  localparam int DEF_ADDR_BITS = 16;
  localparam int DEF_SLOTS     = 4;
  localparam int ADDR_MAX      = 24;
  localparam int WORD_W        = 64;
  localparam int TAG_W         = 16;

  localparam logic [31:0] ALT_MUL   = 32'h5bd1e995;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam logic [1:0] TAG_MODE_4 = 2'd0;
  localparam logic [1:0] TAG_MODE_8 = 2'd1;

  localparam logic [1:0] CFG_TAG_MODE    = 2'd0;
  localparam logic [1:0] CFG_BUCKET_LOG2 = 2'd1;
  localparam logic [1:0] CFG_MAX_KICKS   = 2'd2;

  localparam logic [1:0]  RST_TAG_MODE = 2'd1;
  localparam logic [4:0]  RST_LOG2     = 5'd16;
  localparam logic [11:0] RST_KICKS    = 12'd500;

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  lg;
    logic [11:0] kicks;
  } cfe_cfg_t;

  function automatic logic [TAG_W-1:0] tag_mask(input logic [1:0] mode);
    case (mode)
      TAG_MODE_4: tag_mask = 16'h000F;
      TAG_MODE_8: tag_mask = 16'h00FF;
      default:    tag_mask = 16'hFFFF;
    endcase
  endfunction

  function automatic logic [ADDR_MAX-1:0] bucket_mask(input logic [4:0] lg, input int abits);
    logic [ADDR_MAX-1:0] m;
    for (int j = 0; j < ADDR_MAX; j++) begin
      m[j] = (j < int'(lg)) && (j < abits);
    end
    return m;
  endfunction

  function automatic logic [31:0] alt_prod(input logic [TAG_W-1:0] tag);
    return {16'd0, tag} * ALT_MUL;
  endfunction

  function automatic logic [TAG_W-1:0] get_slot(input logic [WORD_W-1:0] word,
                                                 input logic [1:0] i,
                                                 input logic [1:0] mode);
    case (mode)
      TAG_MODE_4: get_slot = {12'd0, word[{i, 2'b00} +: 4]};
      TAG_MODE_8: get_slot = {8'd0, word[{i, 3'b000} +: 8]};
      default:    get_slot = word[{i, 4'b0000} +: 16];
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] put_slot(input logic [WORD_W-1:0] word,
                                                  input logic [1:0] i,
                                                  input logic [1:0] mode,
                                                  input logic [TAG_W-1:0] val);
    logic [WORD_W-1:0] w;
    w = word;
    case (mode)
      TAG_MODE_4: w[{i, 2'b00} +: 4] = val[3:0];
      TAG_MODE_8: w[{i, 3'b000} +: 8] = val[7:0];
      default:    w[{i, 4'b0000} +: 16] = val;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] lfsr_next(input logic [15:0] l);
    return {l[0] ^ l[2] ^ l[3] ^ l[5], l[15:1]};
  endfunction

  // slot = lfsr mod slot count (two or three slots; low two bits otherwise); base-4 digits fold for three slots
  function automatic logic [1:0] slot_pick(input logic [15:0] l, input int slots);
    logic [4:0] s;
    s = 5'd0;
    if (slots == 3) begin
      for (int k = 0; k < 8; k++) begin
        s = s + {3'd0, l[2*k +: 2]};
      end
      for (int k = 0; k < 8; k++) begin
        if (s >= 5'd3) s = s - 5'd3;
      end
    end else if (slots == 2) begin
      s = {4'd0, l[0]};
    end else begin
      s = {3'd0, l[1:0]};
    end
    return s[1:0];
  endfunction

endpackage

>>> rtl/cfe_ram.sv
`timescale 1ns / 1ps
module cfe_ram #(
  parameter int W  = 64,
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/cfe_queue.sv
`timescale 1ns / 1ps
module cfe_queue #(
  parameter int W = 50
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         nempty,
  output logic [W-1:0] head
);
  logic [W-1:0] ent_r [0:1];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full   = cnt_r == 2'd2;
  assign nempty = cnt_r != 2'd0;
  assign head   = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_data;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> rtl/cfe_front.sv
`timescale 1ns / 1ps
module cfe_front import cfe_pkg::*; #(
  parameter int BUCKET_ADDR_BITS = DEF_ADDR_BITS,
  parameter int QW = 2 + TAG_W + 2 * BUCKET_ADDR_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfe_cfg_t      cfg,
  input  logic          clearing,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_req_type,
  input  logic [63:0]   in_hash_value,
  input  logic          q_full,
  output logic          q_push,
  output logic [QW-1:0] q_data
);
  localparam int A = BUCKET_ADDR_BITS;

  logic                 s1_v_r;
  logic [1:0]           req_r;
  logic [TAG_W-1:0]     tag_r;
  logic [A-1:0]         i1_r, prod_r;
  logic [ADDR_MAX-1:0]  bm_full;
  logic [A-1:0]         bmask, i2;
  logic [TAG_W-1:0]     tag_nxt;
  logic [31:0]          prod;
  logic                 accept;

  assign bm_full  = bucket_mask(cfg.lg, A);
  assign bmask    = bm_full[A-1:0];
  assign in_stall = clearing || (s1_v_r && q_full);
  assign accept   = in_valid && !in_stall;
  assign q_push   = s1_v_r && !q_full;

  always_comb begin
    tag_nxt = in_hash_value[TAG_W-1:0] & tag_mask(cfg.mode);
    if (tag_nxt == '0) tag_nxt = 16'd1;
    prod = alt_prod(tag_nxt);
  end

  assign i2     = (i1_r ^ prod_r) & bmask;
  assign q_data = {req_r, tag_r, i1_r, i2};

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_req_type;
      tag_r  <= tag_nxt;
      i1_r   <= in_hash_value[32 +: A] & bmask;
      prod_r <= prod[A-1:0];
    end
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (q_push) begin
      s1_v_r <= 1'b0;
    end
  end
endmodule

>>> rtl/cfe_back.sv
`timescale 1ns / 1ps
module cfe_back import cfe_pkg::*; #(
  parameter int BUCKET_ADDR_BITS = DEF_ADDR_BITS,
  parameter int SLOTS_PER_BUCKET = DEF_SLOTS,
  parameter int QW = 2 + TAG_W + 2 * BUCKET_ADDR_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfe_cfg_t      cfg,
  output logic          clearing,
  input  logic          q_nempty,
  input  logic [QW-1:0] q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    out_status
);
  localparam int A = BUCKET_ADDR_BITS;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_LK1  = 4'd2;
  localparam logic [3:0] S_LK2  = 4'd3;
  localparam logic [3:0] S_DL1  = 4'd4;
  localparam logic [3:0] S_DL2  = 4'd5;
  localparam logic [3:0] S_PRD  = 4'd6;
  localparam logic [3:0] S_PCHK = 4'd7;
  localparam logic [3:0] S_PALT = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]       st_r, st_nxt;
  logic [A-1:0]     clr_r, clr_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic [A-1:0]     i1_r, i1_nxt, i2_r, i2_nxt;
  logic             vm_r, vm_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [A-1:0]     cur_idx_r, cur_idx_nxt;
  logic [TAG_W-1:0] cur_tag_r, cur_tag_nxt;
  logic [11:0]      kick_r, kick_nxt;
  logic [A-1:0]     prod_r, prod_nxt;
  logic [15:0]      lfsr_r, lfsr_nxt;
  logic             vic_v_r, vic_v_nxt;
  logic [A-1:0]     vic_b_r, vic_b_nxt;
  logic [TAG_W-1:0] vic_t_r, vic_t_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;

  logic              we;
  logic [A-1:0]      waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata;

  logic [1:0]          h_req;
  logic [TAG_W-1:0]    h_tag, key, wmask, pl_tag;
  logic [A-1:0]        h_i1, h_i2, bmask, pl_idx;
  logic [ADDR_MAX-1:0] bm_full;
  logic                h_vm, hit, emp, pl_go;
  logic [1:0]          hit_i, emp_i, ev_i;
  logic [12:0]         kick_inc;
  logic [31:0]         prod_full;

  cfe_ram #(.W(WORD_W), .AW(A)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign {h_req, h_tag, h_i1, h_i2} = q_head;
  assign bm_full    = bucket_mask(cfg.lg, A);
  assign bmask      = bm_full[A-1:0];
  assign wmask      = tag_mask(cfg.mode);
  assign clearing   = st_r == S_CLR;
  assign q_pop      = (st_r == S_IDLE) && q_nempty;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign h_vm = vic_v_r && (vic_t_r == h_tag) && ((vic_b_r == h_i1) || (vic_b_r == h_i2));
  assign key  = (st_r == S_PCHK) ? cur_tag_r : tag_r;
  assign kick_inc = {1'b0, kick_r} + 13'd1;

  // lowest matching and lowest empty slot of the word just read
  always_comb begin
    hit = 1'b0; hit_i = 2'd0; emp = 1'b0; emp_i = 2'd0;
    for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--) begin
      if (get_slot(rdata, 2'(i), cfg.mode) == (key & wmask)) begin
        hit = 1'b1; hit_i = 2'(i);
      end
      if (get_slot(rdata, 2'(i), cfg.mode) == '0) begin
        emp = 1'b1; emp_i = 2'(i);
      end
    end
  end

  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r; tag_nxt = tag_r; i1_nxt = i1_r; i2_nxt = i2_r;
    vm_nxt = vm_r; status_nxt = status_r; cur_idx_nxt = cur_idx_r; cur_tag_nxt = cur_tag_r;
    kick_nxt = kick_r; prod_nxt = prod_r; lfsr_nxt = lfsr_r;
    vic_v_nxt = vic_v_r; vic_b_nxt = vic_b_r; vic_t_nxt = vic_t_r;
    out_valid_nxt = out_valid_r && out_stall; out_status_nxt = out_status_r;
    we = 1'b0; waddr = cur_idx_r; wdata = rdata; raddr = cur_idx_r;
    pl_go = 1'b0; pl_idx = cur_idx_r; pl_tag = cur_tag_r;
    ev_i = 2'd0; prod_full = '0;
    case (st_r)
      S_CLR: begin
        we = 1'b1; waddr = clr_r; wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {A{1'b1}}) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_nempty) begin
          tag_nxt = h_tag; i1_nxt = h_i1; i2_nxt = h_i2; vm_nxt = h_vm;
          raddr = h_i1;
          case (h_req)
            REQ_INSERT: begin
              if (vic_v_r) begin
                status_nxt = STAT_FULL; st_nxt = S_OUT;
              end else begin
                pl_go = 1'b1; pl_idx = h_i1; pl_tag = h_tag;
              end
            end
            REQ_LOOKUP: begin
              if (h_vm) begin
                status_nxt = STAT_OK; st_nxt = S_OUT;
              end else begin
                st_nxt = S_LK1;
              end
            end
            REQ_DELETE: st_nxt = S_DL1;
            default: begin
              status_nxt = STAT_MISS; st_nxt = S_OUT;
            end
          endcase
        end
      end
      S_LK1: begin
        raddr = i2_r;
        if (hit) begin
          status_nxt = STAT_OK; st_nxt = S_OUT;
        end else begin
          st_nxt = S_LK2;
        end
      end
      S_LK2: begin
        status_nxt = hit ? STAT_OK : STAT_MISS;
        st_nxt = S_OUT;
      end
      S_DL1, S_DL2: begin
        raddr = i2_r;
        if (hit) begin
          we = 1'b1;
          waddr = (st_r == S_DL1) ? i1_r : i2_r;
          wdata = put_slot(rdata, hit_i, cfg.mode, '0);
          status_nxt = STAT_OK;
          if (vic_v_r) begin
            vic_v_nxt = 1'b0;
            pl_go = 1'b1; pl_idx = vic_b_r; pl_tag = vic_t_r & wmask;
          end else begin
            st_nxt = S_OUT;
          end
        end else if (st_r == S_DL1) begin
          st_nxt = S_DL2;
        end else begin
          if (vm_r) begin
            vic_v_nxt = 1'b0; status_nxt = STAT_OK;
          end else begin
            status_nxt = STAT_MISS;
          end
          st_nxt = S_OUT;
        end
      end
      S_PRD: st_nxt = S_PCHK;
      S_PCHK: begin
        we = 1'b1;
        if (emp) begin
          wdata = put_slot(rdata, emp_i, cfg.mode, cur_tag_r);
          status_nxt = STAT_OK; st_nxt = S_OUT;
        end else begin
          if (kick_r != '0) begin
            lfsr_nxt = lfsr_next(lfsr_r);
            ev_i = slot_pick(lfsr_nxt, SLOTS_PER_BUCKET);
            wdata = put_slot(rdata, ev_i, cfg.mode, cur_tag_r);
            cur_tag_nxt = get_slot(rdata, ev_i, cfg.mode);
          end else begin
            we = 1'b0;
          end
          prod_full = alt_prod(cur_tag_nxt);
          prod_nxt = prod_full[A-1:0];
          st_nxt = S_PALT;
        end
      end
      S_PALT: begin
        cur_idx_nxt = (cur_idx_r ^ prod_r) & bmask;
        kick_nxt = kick_inc[11:0];
        if (kick_inc == {1'b0, cfg.kicks}) begin
          vic_v_nxt = 1'b1; vic_b_nxt = cur_idx_nxt; vic_t_nxt = cur_tag_r;
          status_nxt = STAT_OK; st_nxt = S_OUT;
        end else begin
          st_nxt = S_PRD;
        end
      end
      S_OUT: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt = 1'b1; out_status_nxt = status_r; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    // start of a placement walk; a zero kick limit parks the tag at once
    if (pl_go) begin
      status_nxt = STAT_OK;
      if (cfg.kicks == '0) begin
        vic_v_nxt = 1'b1; vic_b_nxt = pl_idx; vic_t_nxt = pl_tag;
        st_nxt = S_OUT;
      end else begin
        cur_idx_nxt = pl_idx; cur_tag_nxt = pl_tag; kick_nxt = '0;
        st_nxt = S_PRD;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt; i1_r <= i1_nxt; i2_r <= i2_nxt; vm_r <= vm_nxt;
    status_r <= status_nxt; cur_idx_r <= cur_idx_nxt; cur_tag_r <= cur_tag_nxt;
    kick_r <= kick_nxt; prod_r <= prod_nxt; out_status_r <= out_status_nxt;
    if (!rst_n) begin
      st_r        <= S_CLR;
      clr_r       <= '0;
      lfsr_r      <= LFSR_SEED;
      vic_v_r     <= 1'b0;
      vic_b_r     <= '0;
      vic_t_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      lfsr_r      <= lfsr_nxt;
      vic_v_r     <= vic_v_nxt;
      vic_b_r     <= vic_b_nxt;
      vic_t_r     <= vic_t_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n) lfsr_r != 16'd0)
    else $error("kick lfsr stuck at zero");
  a_kick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_PCHK) |-> (kick_r < cfg.kicks))
    else $error("bucket visit beyond kick limit");
  a_no_pop_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLR) |-> (!q_pop && !out_valid_r))
    else $error("activity during clearing pass");
  a_full_only_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && h_req == REQ_INSERT && vic_v_r) |=> (status_r == STAT_FULL))
    else $error("insert with held victim not refused");
endmodule

>>> rtl/cuckoo_filter_engine.sv
`timescale 1ns / 1ps
// Cuckoo filter engine, four-slot buckets plus one victim entry.
// Input channel: in_valid/in_stall with in_req_type (insert, lookup, delete)
// and a precomputed 64-bit in_hash_value. One result per request on
// out_valid/out_stall with out_status (ok/found, not found, no space).
// cfg_we/cfg_index/cfg_wdata write tag width mode, bucket count log2 and
// kick limit; write only while the engine is idle.
// A front stage forms tag and both bucket indices; a two-entry
// queue decouples it from the back end, which walks the bucket RAM.
// A lookup that hits the victim, a refused insert and an insert with a zero
// kick limit answer without a bucket visit. Otherwise each visit reads the
// word, checks it, writes a free or kicked slot and forms the alternate index;
// an insert parks its tag in the victim when the kick limit is reached. A
// delete that frees a slot while a victim is held adds that reinsertion.
// Requests are served one at a time by the back end, which uses the bucket
// RAM through its separate read and write ports.
// Reset: synchronous, active low. The bucket RAM is then cleared one bucket
// per cycle, every bucket in turn, with in_stall high throughout.
// A stalled result holds in the output register; the back end waits on it
// while the front and queue keep taking requests until the queue fills.
module cuckoo_filter_engine import cfe_pkg::*; #(
  parameter int BUCKET_ADDR_BITS = DEF_ADDR_BITS,
  parameter int SLOTS_PER_BUCKET = DEF_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_hash_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);
  localparam int QW = 2 + TAG_W + 2 * BUCKET_ADDR_BITS;

  cfe_cfg_t        cfg_r;
  logic            clearing, q_full, q_push, q_pop, q_nempty;
  logic [QW-1:0]   q_data, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= RST_TAG_MODE;
      cfg_r.lg    <= RST_LOG2;
      cfg_r.kicks <= RST_KICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TAG_MODE:    cfg_r.mode  <= cfg_wdata[1:0];
        CFG_BUCKET_LOG2: cfg_r.lg    <= cfg_wdata[4:0];
        CFG_MAX_KICKS:   cfg_r.kicks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cfe_front #(.BUCKET_ADDR_BITS(BUCKET_ADDR_BITS), .QW(QW)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .clearing(clearing),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_hash_value(in_hash_value), .q_full(q_full), .q_push(q_push), .q_data(q_data)
  );

  cfe_queue #(.W(QW)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_data), .full(q_full),
    .pop(q_pop), .nempty(q_nempty), .head(q_head)
  );

  cfe_back #(
    .BUCKET_ADDR_BITS(BUCKET_ADDR_BITS), .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET), .QW(QW)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .clearing(clearing),
    .q_nempty(q_nempty), .q_head(q_head), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status)
  );
endmodule

>>> tb/cfe_checker.sv
`timescale 1ns / 1ps
module cfe_checker import cfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_hash_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  logic [63:0] bucket_mem [0:65535];
  bit          vic_held;
  logic [15:0] vic_idx, vic_tag, kick_lfsr;
  logic [1:0]  mode_r;
  logic [4:0]  lg_r;
  logic [11:0] kicks_r;
  logic [1:0]  status_due [$];

  assign pending = status_due.size();

  function automatic int unsigned tag_w();
    if (mode_r == TAG_MODE_4) return 4;
    if (mode_r == TAG_MODE_8) return 8;
    return 16;
  endfunction

  function automatic logic [15:0] idx_mask();
    int unsigned l;
    l = (lg_r > 16) ? 16 : lg_r;
    return 16'((32'd1 << l) - 1);
  endfunction

  function automatic logic [15:0] alt_of(input logic [15:0] idx, input logic [15:0] tag);
    logic [31:0] p;
    p = {16'd0, tag} * ALT_MUL;
    return (idx ^ p[15:0]) & idx_mask();
  endfunction

  function automatic logic [15:0] slot_rd(input logic [63:0] word, input int unsigned i);
    int unsigned w;
    w = tag_w();
    return 16'((word >> (i * w)) & ((64'd1 << w) - 1));
  endfunction

  function automatic logic [63:0] slot_wr(input logic [63:0] word, input int unsigned i,
                                          input logic [15:0] tag);
    logic [63:0] m;
    int unsigned w;
    w = tag_w();
    m = ((64'd1 << w) - 1) << (i * w);
    return (word & ~m) | (({48'd0, tag} << (i * w)) & m);
  endfunction

  function automatic bit bucket_holds(input logic [15:0] idx, input logic [15:0] tag);
    for (int i = 0; i < 4; i++)
      if (slot_rd(bucket_mem[idx], i) == tag) return 1;
    return 0;
  endfunction

  function automatic bit bucket_drop(input logic [15:0] idx, input logic [15:0] tag);
    for (int i = 0; i < 4; i++)
      if (slot_rd(bucket_mem[idx], i) == tag) begin
        bucket_mem[idx] = slot_wr(bucket_mem[idx], i, 0);
        return 1;
      end
    return 0;
  endfunction

  // cuckoo walk: first visit never evicts, later full buckets kick an LFSR slot
  function automatic void cuckoo_place(input logic [15:0] idx, input logic [15:0] tag);
    logic [15:0] cur_idx, cur_tag, evicted;
    logic [63:0] word;
    int unsigned s;
    cur_idx = idx;
    cur_tag = tag & 16'((64'd1 << tag_w()) - 1);
    for (int n = 0; n < int'(kicks_r); n++) begin
      word = bucket_mem[cur_idx];
      for (int i = 0; i < 4; i++)
        if (slot_rd(word, i) == 0) begin
          bucket_mem[cur_idx] = slot_wr(word, i, cur_tag);
          return;
        end
      if (n > 0) begin
        kick_lfsr = {kick_lfsr[0] ^ kick_lfsr[2] ^ kick_lfsr[3] ^ kick_lfsr[5],
                     kick_lfsr[15:1]};
        s = kick_lfsr[1:0];
        evicted = slot_rd(word, s);
        bucket_mem[cur_idx] = slot_wr(word, s, cur_tag);
        cur_tag = evicted;
      end
      cur_idx = alt_of(cur_idx, cur_tag);
    end
    vic_held = 1;
    vic_idx  = cur_idx;
    vic_tag  = cur_tag;
  endfunction

  function automatic logic [1:0] filter_status(input logic [1:0] req, input logic [63:0] h);
    logic [15:0] i1, i2, tag;
    bit vmatch;
    logic [1:0] st;
    i1  = h[47:32] & idx_mask();
    tag = h[15:0] & 16'((64'd1 << tag_w()) - 1);
    if (tag == 0) tag = 16'd1;
    i2 = alt_of(i1, tag);
    vmatch = vic_held && vic_tag == tag && (vic_idx == i1 || vic_idx == i2);
    st = STAT_MISS;
    case (req)
      REQ_INSERT: begin
        if (vic_held) st = STAT_FULL;
        else begin
          cuckoo_place(i1, tag);
          st = STAT_OK;
        end
      end
      REQ_LOOKUP: if (vmatch || bucket_holds(i1, tag) || bucket_holds(i2, tag)) st = STAT_OK;
      REQ_DELETE: begin
        if (bucket_drop(i1, tag) || bucket_drop(i2, tag)) begin
          if (vic_held) begin
            vic_held = 0;
            cuckoo_place(vic_idx, vic_tag);
          end
          st = STAT_OK;
        end else if (vmatch) begin
          vic_held = 0;
          st = STAT_OK;
        end
      end
      default: st = STAT_MISS;
    endcase
    return st;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (bucket_mem[i]) bucket_mem[i] = '0;
      vic_held   = 0;
      vic_idx    = '0;
      vic_tag    = '0;
      kick_lfsr  = LFSR_SEED;
      mode_r     = RST_TAG_MODE;
      lg_r       = RST_LOG2;
      kicks_r    = RST_KICKS;
      fail_count = 0;
      status_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TAG_MODE:    mode_r  = cfg_wdata[1:0];
          CFG_BUCKET_LOG2: lg_r    = cfg_wdata[4:0];
          CFG_MAX_KICKS:   kicks_r = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) status_due.push_back(filter_status(in_req_type, in_hash_value));
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          $error("status: result with no request outstanding, actual %0d", out_status);
          fail_count++;
        end else if (status_due[0] !== out_status) begin
          $error("status: expected %0d, actual %0d", status_due[0], out_status);
          fail_count++;
          void'(status_due.pop_front());
        end else begin
          void'(status_due.pop_front());
        end
      end
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import cfe_pkg::*;

  localparam int WATCHDOG = 400000;
  localparam int SETTLE   = 15000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [63:0] in_hash_value;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_wdata;
  int          fail_count, pending;

  int  idle_mode;   // 0 none, 1 sender, 2 receiver, 3 both lightly
  bit  hold_go;
  int  quiet_cycles;
  int  sent, settings;
  logic [63:0] hash_pool [16];

  cuckoo_filter_engine dut (.*);

  cfe_checker chk (.*);

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // receiver: random stall per idling mode, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk);
        hold_go = 0;
      end else if (idle_mode == 2) out_stall = ($urandom_range(99) < 81);
      else if (idle_mode == 3)     out_stall = ($urandom_range(99) < 6);
      else                         out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] req, input logic [63:0] h);
    int gap;
    gap = (idle_mode == 1) ? 81 : (idle_mode == 3) ? 6 : 0;
    while ($urandom_range(99) < gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_req_type   = req;
    in_hash_value = h;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  task automatic reconfigure(input logic [1:0] mode, input logic [4:0] lg,
                             input logic [11:0] kicks);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (SETTLE) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_TAG_MODE;    cfg_wdata = {10'd0, mode}; @(negedge clk);
    cfg_index = CFG_BUCKET_LOG2; cfg_wdata = {7'd0, lg};    @(negedge clk);
    cfg_index = CFG_MAX_KICKS;   cfg_wdata = kicks;         @(negedge clk);
    cfg_we = 1'b0;
    settings++;
  endtask

  task automatic random_phase(input int items);
    logic [1:0]  req;
    logic [63:0] h;
    int r;
    foreach (hash_pool[i]) hash_pool[i] = {$urandom, $urandom};
    repeat (items) begin
      r = $urandom_range(99);
      req = (r < 45) ? REQ_INSERT : (r < 75) ? REQ_LOOKUP : (r < 97) ? REQ_DELETE : 2'd3;
      h = ($urandom_range(3) != 0) ? hash_pool[$urandom_range(15)] : {$urandom, $urandom};
      send_request(req, h);
    end
  endtask

  initial begin
    logic [1:0]  modes  [8] = '{TAG_MODE_4, TAG_MODE_4, TAG_MODE_8, 2'd2, 2'd3, TAG_MODE_4,
                                2'd2, TAG_MODE_8};
    logic [4:0]  lgs    [8] = '{5'd0, 5'd2, 5'd1, 5'd3, 5'd31, 5'd17, 5'd4, 5'd2};
    logic [11:0] kickss [8] = '{12'd1, 12'd4, 12'd8, 12'd10, 12'd0, 12'd3, 12'd4095, 12'd3};
    int          counts [8] = '{120, 140, 120, 110, 60, 40, 40, 140};
    rst_n = 1'b0;
    in_valid = 1'b0; in_req_type = REQ_INSERT; in_hash_value = '0;
    cfg_we = 1'b0; cfg_index = CFG_TAG_MODE; cfg_wdata = '0;
    idle_mode = 0; hold_go = 0; sent = 0; settings = 1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: zero tag forced to one, extremes of the hash
    send_request(REQ_INSERT, 64'd0);
    send_request(REQ_LOOKUP, 64'd0);
    send_request(REQ_LOOKUP, '1);
    send_request(REQ_INSERT, '1);
    send_request(REQ_LOOKUP, '1);
    send_request(REQ_DELETE, '1);
    send_request(REQ_DELETE, '1);
    send_request(2'd3, 64'h0123_4567_89ab_cdef);
    send_request(REQ_INSERT, 64'hffff_ffff_ffff_ff00);

    // single bucket, one visit: overflow into the victim, then no space
    reconfigure(TAG_MODE_4, 5'd0, 12'd1);
    for (int i = 1; i <= 6; i++) send_request(REQ_INSERT, 64'(i));
    send_request(REQ_LOOKUP, 64'd5);
    send_request(REQ_LOOKUP, 64'd9);
    send_request(REQ_DELETE, 64'd2);   // frees a slot, victim reinserted
    send_request(REQ_LOOKUP, 64'd5);
    send_request(REQ_INSERT, 64'd7);
    send_request(REQ_DELETE, 64'd7);   // victim itself removed
    send_request(REQ_DELETE, 64'd12);

    for (int p = 0; p < 8; p++) begin
      reconfigure(modes[p], lgs[p], kickss[p]);
      idle_mode = p % 4;
      if (p == 1) hold_go = 1;
      random_phase(counts[p]);
    end

    in_valid = 1'b0;
    wait (pending == 0);
    repeat (SETTLE) @(negedge clk);
    $display("Covered %0d requests over %0d settings of tag width, bucket count and kick limit,",
             sent, settings);
    $display("with victim overflow, all idling patterns and a long output hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
